>>> rtl/core/piecewise_constant_integrator_unit_macros.svh
// Assertion macros used by the port-level checker of the integrator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PIECEWISE_CONSTANT_INTEGRATOR_UNIT_MACROS_SVH
`define PIECEWISE_CONSTANT_INTEGRATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PCI_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pci_pkg.sv
// Package for the piecewise constant integrator: sizes, codes, state and
// command types shared by the controller and the datapath. No dependencies.
package pci_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int CFG_W        = 7;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } pci_state_t;

  typedef struct packed {
    logic                 start_query;
    logic                 load_en;
    logic                 rd_en;
    logic                 rd_last;
    logic [SEG_IDX_W-1:0] seg_idx;
    logic                 out_load;
  } pci_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } pci_stat_t;

  // Number of segments a query walks: zero acts as one, large values clamp.
  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (int'(cfg) > MAX_SEGMENTS) begin
      n = CNT_W'(MAX_SEGMENTS);
    end else begin
      n = CNT_W'(cfg);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/pci_ctrl.sv
// Controller of the integrator: handshakes, segment count register and the
// sequencer that walks the table. Depends on pci_pkg.
module pci_ctrl import pci_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pci_cmd_t         cmd,
  input  pci_stat_t        stat
);

  pci_state_t           state, state_next;
  logic [SEG_IDX_W-1:0] seg_k, seg_k_next;
  logic [CFG_W-1:0]     segments_in_use;
  logic                 out_valid_next;
  logic [CNT_W-1:0]     n_active;
  logic                 seg_last;

  assign cfg_ready = 1'b1;
  assign n_active  = active_count(segments_in_use);
  assign seg_last  = (CNT_W'(seg_k) + CNT_W'(1)) == n_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      seg_k           <= '0;
      segments_in_use <= CFG_W'(1);
      out_valid       <= 1'b0;
    end else begin
      state     <= state_next;
      seg_k     <= seg_k_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        segments_in_use <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next  = state;
    seg_k_next  = seg_k;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.seg_idx = seg_k;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ACT_QUERY) begin
            cmd.start_query = 1'b1;
            seg_k_next      = '0;
            state_next      = ST_RUN;
          end else begin
            cmd.load_en = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = seg_last;
        if (seg_last) begin
          state_next = ST_DRAIN;
        end else begin
          seg_k_next = seg_k + SEG_IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // The finished sum waits here until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> rtl/core/pci_datapath.sv
// Datapath of the integrator: the three segment tables, the overlap stage,
// the multiplier and the saturating accumulator. Depends on pci_pkg.
module pci_datapath import pci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pci_cmd_t    cmd,
  output pci_stat_t   stat,
  input  logic [5:0]  entry_index,
  input  logic [31:0] breakpoint_time,
  input  logic [15:0] segment_rate,
  input  logic [31:0] time_start,
  input  logic [31:0] time_end,
  input  logic        use_square,
  output logic [63:0] integral_value,
  output logic        saturated
);

  logic [31:0] bp_mem   [MAX_SEGMENTS];
  logic [15:0] rate_mem [MAX_SEGMENTS];
  logic [31:0] sq_mem   [MAX_SEGMENTS];

  logic [31:0] ts_q, te_q;
  logic        sq_q;

  logic [31:0] bp_rd, sq_rd;
  logic [15:0] rate_rd;
  logic        v1, last1;

  logic [32:0] lo, hi, span_a, span_b;
  logic [31:0] width;
  logic [31:0] factor;

  logic [31:0] width2, factor2;
  logic        v2;
  logic [63:0] prod;
  logic        v3;

  logic [63:0] acc;
  logic        sat;
  logic [64:0] sum;

  logic        wr_ok;
  logic [31:0] rate_sq;

  assign wr_ok   = int'(entry_index) < MAX_SEGMENTS;
  assign rate_sq = 32'(segment_rate) * 32'(segment_rate);

  always_ff @(posedge clk) begin
    if (cmd.load_en && wr_ok) begin
      bp_mem[SEG_IDX_W'(entry_index)]   <= breakpoint_time;
      rate_mem[SEG_IDX_W'(entry_index)] <= segment_rate;
      sq_mem[SEG_IDX_W'(entry_index)]   <= rate_sq;
    end
    if (cmd.rd_en) begin
      bp_rd   <= bp_mem[cmd.seg_idx];
      rate_rd <= rate_mem[cmd.seg_idx];
      sq_rd   <= sq_mem[cmd.seg_idx];
    end
  end

  // Overlap of [time_start, time_end) with the current segment [lo, hi).
  // The last segment in use reaches past every 32-bit time.
  always_comb begin
    if (last1) begin
      hi = 33'h1_0000_0000;
    end else if ({1'b0, bp_rd} > lo) begin
      hi = {1'b0, bp_rd};
    end else begin
      hi = lo;
    end
    span_a = ({1'b0, ts_q} > lo) ? {1'b0, ts_q} : lo;
    span_b = ({1'b0, te_q} < hi) ? {1'b0, te_q} : hi;
    width  = (span_b > span_a) ? 32'(span_b - span_a) : '0;
    // A plain rate is moved up by 15 bits so both kinds land in Q2.30.
    factor = sq_q ? sq_rd : {1'b0, rate_rd, 15'd0};
  end

  assign sum            = {1'b0, acc} + {1'b0, prod};
  assign stat.pipe_busy = v1 | v2 | v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    last1 <= cmd.rd_last;
    if (cmd.start_query) begin
      ts_q <= time_start;
      te_q <= time_end;
      sq_q <= use_square;
      lo   <= '0;
      acc  <= '0;
      sat  <= 1'b0;
    end else begin
      if (v1) begin
        lo <= hi;
      end
      if (v3) begin
        if (sum[64]) begin
          acc <= '1;
          sat <= 1'b1;
        end else begin
          acc <= sum[63:0];
        end
      end
    end
    width2  <= width;
    factor2 <= factor;
    prod    <= 64'(width2) * 64'(factor2);
    if (cmd.out_load) begin
      integral_value <= acc;
      saturated      <= sat;
    end
  end

endmodule

>>> rtl/core/piecewise_constant_integrator_unit.sv
// Top level of the piecewise constant integrator: controller plus datapath.
// Depends on pci_pkg, pci_ctrl and pci_datapath.
//
// Usage: items arrive on in_valid/in_ready. An item with action 0 writes one
// table entry (breakpoint, rate and its square) and makes no result. An item
// with action 1 integrates the rate, or the squared rate, from time_start to
// time_end and makes one result on out_valid/out_ready.
// The cfg channel (cfg_valid/cfg_ready, always ready) sets segments_in_use
// and should only be written while the block has no query in flight.
// A query walks the table one entry per cycle through a memory read, an
// overlap stage, a 32x32 multiplier and the accumulator. One query is in
// flight at a time; a load can be followed at once by the next item. The
// output register lets the next item be accepted while a result waits; a
// stalled receiver holds the next query in its final state until the
// register frees up.
// Reset clears control state and sets segments_in_use to 1; the tables are
// not cleared and must be loaded before queries use them.
module piecewise_constant_integrator_unit import pci_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [5:0]       entry_index,
  input  logic [31:0]      breakpoint_time,
  input  logic [15:0]      segment_rate,
  input  logic [31:0]      time_start,
  input  logic [31:0]      time_end,
  input  logic             use_square,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      integral_value,
  output logic             saturated
);

  pci_cmd_t  cmd;
  pci_stat_t stat;

  pci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pci_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .entry_index     (entry_index),
    .breakpoint_time (breakpoint_time),
    .segment_rate    (segment_rate),
    .time_start      (time_start),
    .time_end        (time_end),
    .use_square      (use_square),
    .integral_value  (integral_value),
    .saturated       (saturated)
  );

endmodule

>>> rtl/core/pci_checker.sv
// Port-level checker for the integrator, bound to the top level.
// Depends on the shared assertion macro header.
`include "piecewise_constant_integrator_unit_macros.svh"

module pci_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] integral_value,
  input logic        saturated
);

  logic        stalled;
  logic [64:0] result_bits;

  assign stalled     = out_valid && !out_ready;
  assign result_bits = {saturated, integral_value};

  // A result only shows after reset once a query has been worked through.
  `PCI_ASSERT_ALWAYS(a_reset_clears_out, rst, !out_valid, "out_valid high after reset")

  // A clipped result must sit at the top of the range.
  `PCI_ASSERT_NOW(a_sat_is_max, out_valid && saturated, &integral_value, "clipped result below max")

  `PCI_ASSERT_NEXT(a_out_holds, stalled, out_valid, "out_valid dropped while stalled")

  `PCI_ASSERT_NEXT(a_out_stable, stalled, $stable(result_bits), "result changed while stalled")

endmodule

bind piecewise_constant_integrator_unit pci_checker u_pci_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .integral_value (integral_value),
  .saturated      (saturated)
);

>>> tb/piecewise_constant_integrator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_constant_integrator_unit: loads rate tables,
// runs integral queries under random flow control and checks every result.
// Depends on pci_pkg and the integrator RTL.
module piecewise_constant_integrator_unit_tb;
  import pci_pkg::*;

  localparam int ITEM_TARGET    = 1950;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_PHASE = 4;
  localparam int MAX_REPORTS    = 100;

  typedef struct {
    logic        action;
    logic [5:0]  entry_index;
    logic [31:0] breakpoint_time;
    logic [15:0] segment_rate;
    logic [31:0] time_start;
    logic [31:0] time_end;
    logic        use_square;
  } pci_item_t;

  typedef struct {
    logic [63:0] value;
    logic        clipped;
  } integral_t;

  class integral_scoreboard;
    logic [31:0]      bp_tab[MAX_SEGMENTS];
    logic [15:0]      rate_tab[MAX_SEGMENTS];
    logic [31:0]      square_tab[MAX_SEGMENTS];
    logic [CFG_W-1:0] seg_reg;
    integral_t        expected_q[$];
    int               mismatches;

    function new();
      seg_reg = 7'd1;
      mismatches = 0;
      foreach (bp_tab[k]) begin
        bp_tab[k] = '0;
        rate_tab[k] = '0;
        square_tab[k] = '0;
      end
    endfunction

    function void set_segments(logic [CFG_W-1:0] v);
      seg_reg = v;
    endfunction

    function int used_count();
      if (seg_reg == '0) return 1;
      if (int'(seg_reg) > MAX_SEGMENTS) return MAX_SEGMENTS;
      return int'(seg_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function integral_t integrate(pci_item_t it);
      integral_t   res;
      logic [32:0] lo, hi, a, b, width;
      logic [63:0] term;
      logic [64:0] total;
      int          n, k;
      res.value = '0;
      res.clipped = 1'b0;
      n = used_count();
      if (it.time_end > it.time_start) begin
        lo = '0;
        for (k = 0; k < n; k++) begin
          // The last segment in use runs on to the end of the time range.
          if (k == n - 1) begin
            hi = 33'h1_0000_0000;
          end else begin
            hi = {1'b0, bp_tab[k]};
            if (hi < lo) hi = lo;
          end
          a = ({1'b0, it.time_start} > lo) ? {1'b0, it.time_start} : lo;
          b = ({1'b0, it.time_end} < hi) ? {1'b0, it.time_end} : hi;
          if (b > a) begin
            width = b - a;
            if (it.use_square) begin
              term = {32'd0, width[31:0]} * {32'd0, square_tab[k]};
            end else begin
              term = ({32'd0, width[31:0]} * {48'd0, rate_tab[k]}) << 15;
            end
            total = {1'b0, res.value} + {1'b0, term};
            if (total[64]) begin
              res.value = '1;
              res.clipped = 1'b1;
            end else begin
              res.value = total[63:0];
            end
          end
          lo = hi;
        end
      end
      return res;
    endfunction

    function void note_item(pci_item_t it);
      if (it.action == ACT_LOAD) begin
        bp_tab[it.entry_index] = it.breakpoint_time;
        rate_tab[it.entry_index] = it.segment_rate;
        square_tab[it.entry_index] = {16'd0, it.segment_rate} * {16'd0, it.segment_rate};
      end else begin
        expected_q.push_back(integrate(it));
      end
    endfunction

    task report(string msg);
      if (mismatches < MAX_REPORTS) $display("[%0t] %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [63:0] value, logic clipped);
      integral_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h arrived with no query outstanding", value));
      end else begin
        want = expected_q.pop_front();
        if (value !== want.value)
          report($sformatf("integral_value %h, expected %h", value, want.value));
        if (clipped !== want.clipped)
          report($sformatf("saturated %b, expected %b", clipped, want.clipped));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             action = ACT_LOAD;
  logic [5:0]       entry_index = '0;
  logic [31:0]      breakpoint_time = '0;
  logic [15:0]      segment_rate = '0;
  logic [31:0]      time_start = '0;
  logic [31:0]      time_end = '0;
  logic             use_square = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [63:0]      integral_value;
  logic             saturated;

  integral_scoreboard sb;
  int items_sent = 0;
  int cycle_count = 0;
  bit burst_mode = 1'b0;
  bit hold_out = 1'b0;

  piecewise_constant_integrator_unit dut (
    .clk, .rst, .in_valid, .in_ready, .action, .entry_index, .breakpoint_time,
    .segment_rate, .time_start, .time_end, .use_square, .cfg_valid, .cfg_ready,
    .cfg_data, .out_valid, .out_ready, .integral_value, .saturated
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("piecewise_constant_integrator_unit_tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(integral_value, saturated);
  end

  // Mostly short gaps, now and then a long one; none at all in burst phases.
  function automatic int idle_len();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : receiver
    int stall;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall - 1) @(posedge clk);
        end
      end
    end
  end

  function automatic pci_item_t random_fill();
    pci_item_t it;
    it.action = ACT_QUERY;
    it.entry_index = 6'($urandom);
    it.breakpoint_time = $urandom;
    it.segment_rate = 16'($urandom);
    it.time_start = $urandom;
    it.time_end = $urandom;
    it.use_square = 1'($urandom);
    return it;
  endfunction

  function automatic pci_item_t make_load(logic [5:0] idx, logic [31:0] bp, logic [15:0] rate);
    pci_item_t it;
    it = random_fill();
    it.action = ACT_LOAD;
    it.entry_index = idx;
    it.breakpoint_time = bp;
    it.segment_rate = rate;
    return it;
  endfunction

  function automatic pci_item_t make_query(logic [31:0] ts, logic [31:0] te, logic sq);
    pci_item_t it;
    it = random_fill();
    it.action = ACT_QUERY;
    it.time_start = ts;
    it.time_end = te;
    it.use_square = sq;
    return it;
  endfunction

  function automatic logic [15:0] pick_rate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Query limits cluster around the breakpoints in use so that segment edges get hit.
  function automatic logic [31:0] pick_time(int n);
    logic [31:0] top;
    int          r;
    top = (n > 1) ? sb.bp_tab[n - 2] : 32'h0010_0000;
    r = $urandom_range(0, 99);
    if (r < 40) return sb.bp_tab[$urandom_range(0, n - 1)] + 32'($urandom_range(0, 8)) - 32'd4;
    if (r < 48) return 32'd0;
    if (r < 56) return 32'hFFFF_FFFF;
    if (r < 72) return $urandom;
    return $urandom_range(0, top);
  endfunction

  function automatic pci_item_t random_query(int n);
    logic [31:0] p, q, t;
    int          r;
    p = pick_time(n);
    q = pick_time(n);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      q = p;
    end else if (r < 85 && p > q) begin
      t = p;
      p = q;
      q = t;
    end
    return make_query(p, q, 1'($urandom));
  endfunction

  function automatic pci_item_t random_load();
    int          idx;
    logic [31:0] lo, hi, bp;
    idx = $urandom_range(0, MAX_SEGMENTS - 1);
    lo = (idx > 0) ? sb.bp_tab[idx - 1] : 32'd0;
    hi = (idx < MAX_SEGMENTS - 1) ? sb.bp_tab[idx + 1] : 32'hFFFF_FFFF;
    if ($urandom_range(0, 9) < 4 || hi < lo) bp = $urandom;
    else bp = $urandom_range(lo, hi);
    return make_load(6'(idx), bp, pick_rate());
  endfunction

  task automatic send_item(pci_item_t it);
    int gap;
    in_valid <= 1'b1;
    action <= it.action;
    entry_index <= it.entry_index;
    breakpoint_time <= it.breakpoint_time;
    segment_rate <= it.segment_rate;
    time_start <= it.time_start;
    time_end <= it.time_end;
    use_square <= it.use_square;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    items_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid, waits for every outstanding result, then lets the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_segments(logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_segments(v);
    cfg_valid <= 1'b0;
  endtask

  // Reloads entries 0..n-1 with non-decreasing breakpoints; a zero step leaves an
  // empty segment.
  task automatic load_ramp(int n);
    logic [32:0] cur;
    logic [31:0] stride;
    int          k;
    case ($urandom_range(0, 2))
      0: stride = 32'd8;
      1: stride = 32'h0010_0000;
      default: stride = 32'hFFFF_FFFF / 32'(n + 1);
    endcase
    cur = 33'($urandom_range(0, stride));
    for (k = 0; k < n; k++) begin
      if (cur > 33'h0_FFFF_FFFF) cur = 33'h0_FFFF_FFFF;
      send_item(make_load(6'(k), cur[31:0], pick_rate()));
      cur = cur + 33'($urandom_range(0, stride));
    end
  endtask

  initial begin : stimulus
    int               phase_no, n, nq, r;
    logic [CFG_W-1:0] seg_val;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One segment: the only rate runs over the whole time range.
    send_item(make_load(6'd0, 32'h0001_0000, 16'hFFFF));
    send_item(make_query(32'd0, 32'hFFFF_FFFF, 1'b0));
    send_item(make_query(32'd0, 32'hFFFF_FFFF, 1'b1));
    send_item(make_query(32'd5, 32'd5, 1'b1));
    send_item(make_query(32'd100, 32'd50, 1'b0));
    settle();
    write_segments(7'd0);
    send_item(make_query(32'h0000_8000, 32'h0003_0000, 1'b1));
    settle();

    // Four segments, the second breakpoint below the first.
    write_segments(7'd4);
    send_item(make_load(6'd0, 32'h0002_0000, 16'h8000));
    send_item(make_load(6'd1, 32'h0001_0000, 16'h1234));
    send_item(make_load(6'd2, 32'h0005_0000, 16'hFFFF));
    send_item(make_load(6'd3, 32'hFFFF_FFFF, 16'h0001));
    send_item(make_query(32'h0000_8000, 32'h0001_8000, 1'b0));
    send_item(make_query(32'h0001_8000, 32'h0004_0000, 1'b1));
    send_item(make_query(32'h0002_0000, 32'h0005_0000, 1'b0));
    send_item(make_query(32'h0004_0000, 32'hFFFF_FFFF, 1'b1));
    send_item(make_query(32'd0, 32'hFFFF_FFFF, 1'b0));
    settle();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase_no)
        0: seg_val = 7'd127;
        1: seg_val = 7'd64;
        2: seg_val = 7'd1;
        3: seg_val = 7'd65;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 50) seg_val = 7'($urandom_range(1, 8));
          else if (r < 80) seg_val = 7'($urandom_range(9, 32));
          else if (r < 92) seg_val = 7'($urandom_range(33, 64));
          else if (r < 96) seg_val = 7'd0;
          else seg_val = 7'($urandom_range(65, 127));
        end
      endcase
      write_segments(seg_val);
      n = sb.used_count();
      // The first phase walks all entries, so every entry is written from here on.
      if (phase_no == 0 || $urandom_range(0, 2) == 0) load_ramp(n);
      burst_mode = ($urandom_range(0, 3) == 0) || (phase_no == PRESSURE_PHASE);
      if (phase_no == PRESSURE_PHASE) hold_out = 1'b1;
      nq = $urandom_range(15, 50);
      repeat (nq) begin
        if ($urandom_range(0, 9) == 0) send_item(random_load());
        else send_item(random_query(n));
      end
      settle();
      phase_no++;
    end

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("piecewise_constant_integrator_unit_tb: PASS");
    end else begin
      $display("piecewise_constant_integrator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
